// ----- rtl/wdh_pkg.sv -----
// Package of shared constants and types for the weighted distance histogram.
`timescale 1ns / 1ps
package wdh_pkg;
  localparam int BINS = 32;
  localparam int BIN_W = $clog2(BINS);
  localparam int DIV_CNT_W = (BIN_W > 1) ? $clog2(BIN_W) : 1;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(BIN_W - 1);
  localparam int ACC_W = 48;
  localparam logic [ACC_W-1:0] SAT48 = {ACC_W{1'b1}};
  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(BINS - 1);
  localparam logic [31:0] RANGE_LOW_RESET = 32'hFFFF0000;
  localparam logic [30:0] RANGE_HIGH_RESET = 31'h00010000;
  localparam logic REG_RANGE_LOW = 1'b0;
  localparam logic REG_RANGE_HIGH = 1'b1;
  localparam int QD = 4;

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic [31:0] weight;
    logic last;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE, F_CLASS, F_DIV, F_EMIT
  } front_state_t;

  typedef enum logic [2:0] {
    S_ACC, S_DRAIN_RD, S_DIV, S_DIV_RUN, S_OUT
  } back_state_t;
endpackage

// ----- rtl/wdh_front.sv -----
// Front part: path distance, side sign and bin selection for each placement.
`timescale 1ns / 1ps
module wdh_front import wdh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [31:0] proximal_len,
  input  logic [31:0] edge_len,
  input  logic [31:0] dist_primary,
  input  logic [31:0] dist_secondary,
  input  logic root_side,
  input  logic [31:0] weight,
  input  logic last_item,
  input  logic signed [31:0] range_low,
  input  logic [30:0] range_high,
  output logic job_valid,
  input  logic job_ready,
  output job_t job
);
  // Stage 1 registers position; stage 2 runs a serial bin divider.
  front_state_t state, state_next;
  logic signed [34:0] x;
  logic [31:0] w;
  logic l;
  logic [BIN_W-1:0] bin;
  logic [39:0] rem;
  logic [39:0] dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic signed [34:0] pd, sd, path_len, xn, lo, hi, off;

  assign pd = 35'(proximal_len) + 35'(dist_primary);
  assign sd = 35'(edge_len) - 35'(proximal_len) + 35'(dist_secondary);
  assign path_len = (pd < sd) ? pd : sd;
  assign xn = root_side ? path_len : -path_len;
  assign lo = 35'(range_low);
  assign hi = 35'(range_high);
  assign off = x - lo;

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: if (in_valid) state_next = F_CLASS;
      F_CLASS: state_next = (x < lo || x >= hi) ? F_EMIT : F_DIV;
      F_DIV: if (cnt == DIV_LAST) state_next = F_EMIT;
      F_EMIT: if (job_ready) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready = state == F_IDLE;
    job_valid = state == F_EMIT;
    job = '{bin: bin, weight: w, last: l};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
      case (state)
        F_IDLE: if (in_valid) begin
          x <= xn;
          w <= weight;
          l <= last_item;
        end
        F_CLASS: begin
          rem <= 40'(off) * 40'(BINS);
          dvs <= 40'(33'(hi - lo)) << (BIN_W - 1);
          bin <= (x < lo) ? '0 : LAST_BIN;
          cnt <= '0;
        end
        F_DIV: begin
          if (rem >= dvs) begin
            rem <= rem - dvs;
            bin <= BIN_W'({bin, 1'b1});
          end else begin
            bin <= BIN_W'({bin, 1'b0});
          end
          dvs <= dvs >> 1;
          cnt <= cnt + 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- rtl/wdh_queue.sv -----
// Short queue of classified placements between the front and back parts.
`timescale 1ns / 1ps
module wdh_queue import wdh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);
  job_t mem [QD];
  logic [$clog2(QD)-1:0] wp, rp;
  logic [$clog2(QD):0] cnt;
  assign wr_ready = cnt != ($clog2(QD)+1)'(QD);
  assign rd_valid = cnt != '0;
  assign rd_data = mem[rp];
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr_valid && wr_ready) begin
        mem[wp] <= wr_data;
        wp <= wp + 1'b1;
      end
      if (rd_valid && rd_ready) rp <= rp + 1'b1;
      cnt <= cnt + ($clog2(QD)+1)'(wr_valid && wr_ready) - ($clog2(QD)+1)'(rd_valid && rd_ready);
    end
  end
endmodule

// ----- rtl/wdh_back.sv -----
// Back part: bin accumulation, total, and normalised emission.
`timescale 1ns / 1ps
module wdh_back import wdh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  output logic job_ready,
  input  job_t job,
  output logic out_valid,
  input  logic out_ready,
  output logic [BIN_W-1:0] out_bin,
  output logic [16:0] out_frac,
  output logic out_zero,
  output logic out_last
);
  back_state_t state, state_next;
  logic [ACC_W-1:0] store [BINS];
  logic [ACC_W-1:0] total, num, rem, bin_v;
  logic [BIN_W-1:0] k;
  logic [16:0] q;
  logic [4:0] step;
  logic [ACC_W:0] sum_b, sum_t, trial;

  assign sum_b = {1'b0, store[job.bin]} + (ACC_W+1)'(job.weight);
  assign sum_t = {1'b0, total} + (ACC_W+1)'(job.weight);
  assign trial = {rem, num[ACC_W-1]} - {1'b0, total};
  assign job_ready = state == S_ACC;

  always_comb begin
    state_next = state;
    case (state)
      S_ACC: if (job_valid && job.last) state_next = S_DRAIN_RD;
      S_DRAIN_RD: state_next = S_DIV;
      S_DIV: state_next = S_DIV_RUN;
      S_DIV_RUN: if (step == 5'd16 || total == '0) state_next = S_OUT;
      S_OUT: if (out_valid && out_ready) state_next = (k == LAST_BIN) ? S_ACC : S_DRAIN_RD;
      default: state_next = S_ACC;
    endcase
  end

  always_comb begin
    out_valid = state == S_OUT;
    out_bin = k;
    out_frac = q;
    out_zero = total == '0;
    out_last = k == LAST_BIN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
      total <= '0;
      k <= '0;
      for (int i = 0; i < BINS; i++) store[i] <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_ACC: if (job_valid) begin
          store[job.bin] <= sum_b[ACC_W] ? SAT48 : sum_b[ACC_W-1:0];
          total <= sum_t[ACC_W] ? SAT48 : sum_t[ACC_W-1:0];
          k <= '0;
        end
        S_DRAIN_RD: bin_v <= store[k];
        S_DIV: begin
          // Restoring division of bin*65536 by total; bin <= total, so quotient fits 17 bits.
          rem <= '0;
          num <= bin_v;
          q <= '0;
          step <= '0;
        end
        S_DIV_RUN: begin
          step <= step + 1'b1;
          if (step == 5'd0) begin
            if (bin_v >= total && total != '0) begin
              q <= 17'd1;
              rem <= bin_v - total;
            end else rem <= bin_v;
          end else if (trial[ACC_W] == 1'b0 || rem[ACC_W-1]) begin
            rem <= trial[ACC_W-1:0];
            q <= {q[15:0], 1'b1};
          end else begin
            rem <= {rem[ACC_W-2:0], 1'b0};
            q <= {q[15:0], 1'b0};
          end
          num <= '0;
        end
        S_OUT: if (out_valid && out_ready) begin
          store[k] <= '0;
          k <= k + 1'b1;
          if (k == LAST_BIN) total <= '0;
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_frac: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_frac <= 17'h10000) else $error("fraction above one");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_zero) |-> out_frac == '0) else $error("zero total fraction");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_bin)) else $error("output lost");
`endif
endmodule

// ----- rtl/weighted_distance_histogram.sv -----
// Top level of the weighted distance histogram block.
`timescale 1ns / 1ps
// Accepts a new placement only after the previous one has left the front; a placement inside
// the range passes through the front's five-step serial bin divider, while one below or above
// the range skips it. A four-entry queue decouples the front from the accumulator, which takes
// one transfer per cycle while it is accumulating. After the last placement the back part emits
// 32 bins, each through its serial fraction divider (which ends early when the total is zero),
// and further placements stall once the queue is full.
module weighted_distance_histogram import wdh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // proximal_len, edge_len, dist_primary, dist_secondary, root_side, weight, pad
  input  logic [167:0] s_tdata,
  input  logic s_tlast,
  output logic m_tvalid,
  input  logic m_tready,
  // bin_number, bin_fraction, zero_total
  output logic [23:0] m_tdata,
  output logic m_tlast,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [31:0] cfg_data
);
  logic signed [31:0] range_low;
  logic [30:0] range_high;
  logic fv, fr, bv, br;
  job_t fj, bj;
  logic [BIN_W-1:0] ob;
  logic [16:0] of;
  logic oz;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low <= RANGE_LOW_RESET;
      range_high <= RANGE_HIGH_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_RANGE_LOW) range_low <= cfg_data;
      else if (cfg_index == REG_RANGE_HIGH) range_high <= cfg_data[30:0];
    end
  end

  wdh_front u_front (.clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready),
    .proximal_len(s_tdata[31:0]), .edge_len(s_tdata[63:32]),
    .dist_primary(s_tdata[95:64]), .dist_secondary(s_tdata[127:96]),
    .root_side(s_tdata[128]), .weight(s_tdata[160:129]), .last_item(s_tlast),
    .range_low, .range_high, .job_valid(fv), .job_ready(fr), .job(fj));
  wdh_queue u_queue (.clk, .rst, .wr_valid(fv), .wr_ready(fr), .wr_data(fj),
    .rd_valid(bv), .rd_ready(br), .rd_data(bj));
  wdh_back u_back (.clk, .rst, .job_valid(bv), .job_ready(br), .job(bj),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_bin(ob), .out_frac(of),
    .out_zero(oz), .out_last(m_tlast));
  assign m_tdata = {oz, of, 6'(ob)};
endmodule
